/* hdl/dlpr_pkg.sv */
// ----------------------------------------------------------------------------
// dlpr_pkg
// Shared types and constants for the longest-path rank block.
// ----------------------------------------------------------------------------
package dlpr_pkg;

    localparam int MAX_NODES = 64;
    localparam int NODE_W    = 6;   // node index width
    localparam int NCNT_W    = 7;   // node count width (holds MAX_NODES)
    localparam int GAP_W     = 8;
    localparam int RANK_W    = 16;
    localparam int ALU_W     = 18;  // signed width of the shared adder

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_RUN = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CLR,
        ST_IND_RD, ST_IND_CHK, ST_IND_WR,
        ST_SEED_RD, ST_SEED_CHK,
        ST_KQ_RD, ST_KQ_CUR, ST_K_RD, ST_K_CHK, ST_K_WR,
        ST_ORDER_CHK,
        ST_F_ID, ST_F_ID2, ST_F_RD, ST_F_CHK, ST_F_ACC,
        ST_R_ID, ST_R_ID2, ST_R_CUR, ST_R_RD, ST_R_CHK, ST_R_ACC,
        ST_O_RD, ST_O_SHOW, ST_O_WAIT,
        ST_DONE
    } rank_state_t;

    // Edge gap: values below one act as one.
    function automatic logic [GAP_W-2:0] eff_gap(input logic [GAP_W-1:0] raw);
        logic signed [GAP_W-1:0] g;
        g = $signed(raw);
        if (g < 1)
            eff_gap = (GAP_W-1)'(1);
        else
            eff_gap = raw[GAP_W-2:0];
    endfunction

endpackage

/* hdl/dlpr_ram.sv */
// ----------------------------------------------------------------------------
// dlpr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dlpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/dag_longest_path_rank.sv */
// ----------------------------------------------------------------------------
// dag_longest_path_rank
// Longest-path layering of a directed graph with a tightening pass.
// ----------------------------------------------------------------------------
// Edge transactions (s_tuser = 0) are accepted while idle and stored in edge
// load order; a run transaction (s_tuser = 1) clears the ranks, builds a Kahn
// order (identity order if a cycle leaves it short), runs a forward and a
// reverse pass and then streams one rank per node in ascending index. The
// Kahn scan and each of the two rank passes walk the whole edge RAM once per
// node through a single read port and one shared adder. Each result is held
// until m_tready. s_tready is low for the whole run.
// ----------------------------------------------------------------------------
module dag_longest_path_rank
    import dlpr_pkg::*;
#(
    parameter int MAX_EDGES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration: node_count
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [5:0] source_node, [11:6] target_node,
                                   // [19:12] min_length, [23:20] zero
    input  logic [0:0]  s_tuser,   // [0] op
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [5:0] node_index, [21:6] node_rank,
                                   // [22] order_fallback, [23] edges_dropped
    output logic        m_tlast
);

    localparam int EAW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW  = $clog2(MAX_EDGES + 1);
    localparam int PW   = $clog2(MAX_EDGES + 1);
    localparam int EDW  = 2 * NODE_W + GAP_W;

    rank_state_t state_reg, state_next;

    logic [NCNT_W-1:0] node_count_reg;
    logic [NCNT_W-1:0] n_reg, n_next;
    logic [ECW-1:0]    edge_total_reg, edge_total_next;
    logic              overflow_reg, overflow_next;
    logic [ECW-1:0]    e_reg, e_next;
    logic [NCNT_W-1:0] k_reg, k_next;
    logic [NCNT_W-1:0] fill_reg, fill_next;
    logic [NCNT_W-1:0] head_reg, head_next;
    logic [NODE_W-1:0] id_reg, id_next;
    logic [NODE_W-1:0] tgt_reg, tgt_next;
    logic [GAP_W-2:0]  gap_reg, gap_next;
    logic              fallback_reg, fallback_next;
    logic [RANK_W-1:0] best_reg, best_next;
    logic [RANK_W-1:0] cur_reg, cur_next;
    logic signed [ALU_W-1:0] low_reg, low_next;
    logic              any_reg, any_next;
    logic              mvalid_reg, mvalid_next;
    logic [23:0]       mdata_reg, mdata_next;
    logic              mlast_reg, mlast_next;

    // RAM ports
    logic              e_we;
    logic [EAW-1:0]    e_waddr, e_raddr;
    logic [EDW-1:0]    e_wdata, e_rdata;
    logic              r_we;
    logic [NODE_W-1:0] r_waddr, r_raddr;
    logic [RANK_W-1:0] r_wdata, r_rdata;
    logic              p_we;
    logic [NODE_W-1:0] p_waddr, p_raddr;
    logic [PW-1:0]     p_wdata, p_rdata;
    logic              o_we;
    logic [NODE_W-1:0] o_waddr, o_raddr;
    logic [NODE_W-1:0] o_wdata, o_rdata;

    // Shared adder
    logic signed [ALU_W-1:0] alu_a, alu_b, alu_sum;

    // Decoded edge read data
    logic [NODE_W-1:0] ed_tail, ed_head;
    logic [GAP_W-1:0]  ed_gap;
    logic              ed_ok;

    assign ed_tail = e_rdata[NODE_W-1:0];
    assign ed_head = e_rdata[2*NODE_W-1:NODE_W];
    assign ed_gap  = e_rdata[EDW-1:2*NODE_W];
    assign ed_ok   = ({1'b0, ed_tail} < n_reg) && ({1'b0, ed_head} < n_reg);
    assign alu_sum = alu_a + alu_b;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = mvalid_reg;
    assign m_tdata   = mdata_reg;
    assign m_tlast   = mlast_reg;

    dlpr_ram #(.WIDTH(EDW), .DEPTH(MAX_EDGES)) u_edge_ram (
        .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
        .raddr(e_raddr), .rdata(e_rdata)
    );
    dlpr_ram #(.WIDTH(RANK_W), .DEPTH(MAX_NODES)) u_rank_ram (
        .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
        .raddr(r_raddr), .rdata(r_rdata)
    );
    dlpr_ram #(.WIDTH(PW), .DEPTH(MAX_NODES)) u_pend_ram (
        .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .raddr(p_raddr), .rdata(p_rdata)
    );
    dlpr_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_order_ram (
        .clk(clk), .we(o_we), .waddr(o_waddr), .wdata(o_wdata),
        .raddr(o_raddr), .rdata(o_rdata)
    );

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            node_count_reg <= cfg_data;
        end
    end

    // State and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            edge_total_reg <= '0;
            overflow_reg   <= 1'b0;
            mvalid_reg     <= 1'b0;
            fill_reg       <= '0;
            head_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            edge_total_reg <= edge_total_next;
            overflow_reg   <= overflow_next;
            mvalid_reg     <= mvalid_next;
            fill_reg       <= fill_next;
            head_reg       <= head_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        e_reg        <= e_next;
        k_reg        <= k_next;
        id_reg       <= id_next;
        tgt_reg      <= tgt_next;
        gap_reg      <= gap_next;
        fallback_reg <= fallback_next;
        best_reg     <= best_next;
        cur_reg      <= cur_next;
        low_reg      <= low_next;
        any_reg      <= any_next;
        mdata_reg    <= mdata_next;
        mlast_reg    <= mlast_next;
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        n_next          = n_reg;
        edge_total_next = edge_total_reg;
        overflow_next   = overflow_reg;
        e_next          = e_reg;
        k_next          = k_reg;
        fill_next       = fill_reg;
        head_next       = head_reg;
        id_next         = id_reg;
        tgt_next        = tgt_reg;
        gap_next        = gap_reg;
        fallback_next   = fallback_reg;
        best_next       = best_reg;
        cur_next        = cur_reg;
        low_next        = low_reg;
        any_next        = any_reg;
        mvalid_next     = mvalid_reg;
        mdata_next      = mdata_reg;
        mlast_next      = mlast_reg;

        e_we    = 1'b0;
        e_waddr = edge_total_reg[EAW-1:0];
        e_wdata = s_tdata[EDW-1:0];
        e_raddr = e_reg[EAW-1:0];
        r_we    = 1'b0;
        r_waddr = id_reg;
        r_wdata = '0;
        r_raddr = ed_tail;
        p_we    = 1'b0;
        p_waddr = tgt_reg;
        p_wdata = '0;
        p_raddr = ed_head;
        o_we    = 1'b0;
        o_waddr = fill_reg[NODE_W-1:0];
        o_wdata = tgt_reg;
        o_raddr = k_reg[NODE_W-1:0];
        alu_a   = '0;
        alu_b   = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser[0] == OP_RUN)
                    begin
                        n_next = (node_count_reg > NCNT_W'(MAX_NODES)) ?
                                 NCNT_W'(MAX_NODES) : node_count_reg;
                        k_next     = '0;
                        state_next = ST_CLR;
                    end
                    else if (edge_total_reg < ECW'(MAX_EDGES))
                    begin
                        e_we            = 1'b1;
                        edge_total_next = edge_total_reg + 1'b1;
                    end
                    else
                    begin
                        overflow_next = 1'b1;
                    end
                end
            end

            // clear ranks and indegrees
            ST_CLR:
            begin
                if (k_reg == n_reg)
                begin
                    e_next     = '0;
                    state_next = ST_IND_RD;
                end
                else
                begin
                    r_we    = 1'b1;
                    r_waddr = k_reg[NODE_W-1:0];
                    p_we    = 1'b1;
                    p_waddr = k_reg[NODE_W-1:0];
                    k_next  = k_reg + 1'b1;
                end
            end

            // count indegrees
            ST_IND_RD:
            begin
                if (e_reg == edge_total_reg)
                begin
                    k_next     = '0;
                    fill_next  = '0;
                    head_next  = '0;
                    state_next = ST_SEED_RD;
                end
                else
                begin
                    state_next = ST_IND_CHK;
                end
            end
            ST_IND_CHK:
            begin
                tgt_next = ed_head;
                if (ed_ok)
                begin
                    state_next = ST_IND_WR;
                end
                else
                begin
                    e_next     = e_reg + 1'b1;
                    state_next = ST_IND_RD;
                end
            end
            ST_IND_WR:
            begin
                alu_a      = ALU_W'(p_rdata);
                alu_b      = ALU_W'(1);
                p_we       = 1'b1;
                p_wdata    = alu_sum[PW-1:0];
                e_next     = e_reg + 1'b1;
                state_next = ST_IND_RD;
            end

            // seed the queue with zero-indegree nodes
            ST_SEED_RD:
            begin
                p_raddr = k_reg[NODE_W-1:0];
                if (k_reg == n_reg)
                begin
                    state_next = ST_KQ_RD;
                end
                else
                begin
                    state_next = ST_SEED_CHK;
                end
            end
            ST_SEED_CHK:
            begin
                if (p_rdata == '0)
                begin
                    o_we      = 1'b1;
                    o_wdata   = k_reg[NODE_W-1:0];
                    fill_next = fill_reg + 1'b1;
                end
                k_next     = k_reg + 1'b1;
                state_next = ST_SEED_RD;
            end

            // Kahn queue
            ST_KQ_RD:
            begin
                o_raddr = head_reg[NODE_W-1:0];
                if (head_reg == fill_reg)
                begin
                    state_next = ST_ORDER_CHK;
                end
                else
                begin
                    head_next  = head_reg + 1'b1;
                    state_next = ST_KQ_CUR;
                end
            end
            ST_KQ_CUR:
            begin
                id_next    = o_rdata;
                e_next     = '0;
                state_next = ST_K_RD;
            end
            ST_K_RD:
            begin
                if (e_reg == edge_total_reg)
                begin
                    state_next = ST_KQ_RD;
                end
                else
                begin
                    state_next = ST_K_CHK;
                end
            end
            ST_K_CHK:
            begin
                tgt_next = ed_head;
                if (ed_ok && ed_tail == id_reg)
                begin
                    state_next = ST_K_WR;
                end
                else
                begin
                    e_next     = e_reg + 1'b1;
                    state_next = ST_K_RD;
                end
            end
            ST_K_WR:
            begin
                alu_a   = ALU_W'(p_rdata);
                alu_b   = -ALU_W'(1);
                p_we    = 1'b1;
                p_wdata = alu_sum[PW-1:0];
                if (alu_sum[PW-1:0] == '0 && fill_reg < NCNT_W'(MAX_NODES))
                begin
                    o_we      = 1'b1;
                    fill_next = fill_reg + 1'b1;
                end
                e_next     = e_reg + 1'b1;
                state_next = ST_K_RD;
            end

            ST_ORDER_CHK:
            begin
                fallback_next = (fill_reg != n_reg);
                k_next        = '0;
                state_next    = ST_F_ID;
            end

            // forward pass
            ST_F_ID:
            begin
                if (k_reg == n_reg)
                begin
                    state_next = ST_R_ID;
                end
                else
                begin
                    state_next = ST_F_ID2;
                end
            end
            ST_F_ID2:
            begin
                id_next    = fallback_reg ? k_reg[NODE_W-1:0] : o_rdata;
                best_next  = '0;
                e_next     = '0;
                state_next = ST_F_RD;
            end
            ST_F_RD:
            begin
                if (e_reg == edge_total_reg)
                begin
                    r_we       = 1'b1;
                    r_wdata    = best_reg;
                    k_next     = k_reg + 1'b1;
                    state_next = ST_F_ID;
                end
                else
                begin
                    state_next = ST_F_CHK;
                end
            end
            ST_F_CHK:
            begin
                gap_next = eff_gap(ed_gap);
                if (ed_ok && ed_head == id_reg)
                begin
                    state_next = ST_F_ACC;
                end
                else
                begin
                    e_next     = e_reg + 1'b1;
                    state_next = ST_F_RD;
                end
            end
            ST_F_ACC:
            begin
                alu_a = ALU_W'(r_rdata);
                alu_b = ALU_W'(gap_reg);
                if (alu_sum > ALU_W'(2**RANK_W - 1))
                begin
                    best_next = '1;
                end
                else if (alu_sum[RANK_W-1:0] > best_reg)
                begin
                    best_next = alu_sum[RANK_W-1:0];
                end
                e_next     = e_reg + 1'b1;
                state_next = ST_F_RD;
            end

            // reverse pass
            ST_R_ID:
            begin
                o_raddr = 6'(k_reg - 1'b1);
                if (k_reg == '0)
                begin
                    k_next     = '0;
                    state_next = ST_O_RD;
                end
                else
                begin
                    state_next = ST_R_ID2;
                end
            end
            ST_R_ID2:
            begin
                id_next    = fallback_reg ? 6'(k_reg - 1'b1) : o_rdata;
                r_raddr    = fallback_reg ? 6'(k_reg - 1'b1) : o_rdata;
                state_next = ST_R_CUR;
            end
            ST_R_CUR:
            begin
                cur_next   = r_rdata;
                any_next   = 1'b0;
                low_next   = '0;
                e_next     = '0;
                state_next = ST_R_RD;
            end
            ST_R_RD:
            begin
                if (e_reg == edge_total_reg)
                begin
                    if (any_reg && low_reg > $signed(ALU_W'(cur_reg)))
                    begin
                        r_we    = 1'b1;
                        r_wdata = low_reg[RANK_W-1:0];
                    end
                    k_next     = k_reg - 1'b1;
                    state_next = ST_R_ID;
                end
                else
                begin
                    state_next = ST_R_CHK;
                end
            end
            ST_R_CHK:
            begin
                gap_next = eff_gap(ed_gap);
                r_raddr  = ed_head;
                if (ed_ok && ed_tail == id_reg)
                begin
                    state_next = ST_R_ACC;
                end
                else
                begin
                    e_next     = e_reg + 1'b1;
                    state_next = ST_R_RD;
                end
            end
            ST_R_ACC:
            begin
                alu_a = ALU_W'(r_rdata);
                alu_b = -ALU_W'(gap_reg);
                if (!any_reg || alu_sum < low_reg)
                begin
                    low_next = alu_sum;
                end
                any_next   = 1'b1;
                e_next     = e_reg + 1'b1;
                state_next = ST_R_RD;
            end

            // stream results
            ST_O_RD:
            begin
                r_raddr = k_reg[NODE_W-1:0];
                if (k_reg == n_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_O_SHOW;
                end
            end
            ST_O_SHOW:
            begin
                mdata_next  = {overflow_reg, fallback_reg, r_rdata, k_reg[NODE_W-1:0]};
                mlast_next  = (k_reg + 1'b1 == n_reg);
                mvalid_next = 1'b1;
                state_next  = ST_O_WAIT;
            end
            ST_O_WAIT:
            begin
                if (m_tready)
                begin
                    mvalid_next = 1'b0;
                    k_next      = k_reg + 1'b1;
                    state_next  = ST_O_RD;
                end
            end

            ST_DONE:
            begin
                edge_total_next = '0;
                overflow_next   = 1'b0;
                state_next      = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Checks
    a_out_only_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> state_reg == ST_O_WAIT)
        else $error("result valid outside output wait");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready while a result is pending");

    a_edge_bound: assert property (@(posedge clk) disable iff (!rst_n)
        edge_total_reg <= ECW'(MAX_EDGES))
        else $error("edge count beyond capacity");

    a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= fill_reg)
        else $error("queue head passed queue tail");

    a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DONE |=> edge_total_reg == '0 && !overflow_reg)
        else $error("edge store not emptied after a run");

endmodule

/* dv/dag_longest_path_rank_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dag_longest_path_rank_test
// Self-checking testbench for the longest-path rank block.
// ----------------------------------------------------------------------------
// Edge and run transactions are queued by the stimulus process and sent by a
// bursty driver. Every accepted transaction updates a local graph ranker that
// queues the per-node ranks a run must produce. A monitor with its own stall
// pattern compares each result transaction field by field. The node count is
// rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module dag_longest_path_rank_test
    import dlpr_pkg::*;
();

    localparam int EDGE_CAP   = 256;
    localparam int IDLE_LIMIT = 400000;
    localparam int SETTLE     = 40;

    typedef struct packed {
        logic       op;
        logic [5:0] tail;
        logic [5:0] head;
        logic [7:0] gap;
    } graph_item_t;

    typedef struct packed {
        logic [5:0]  node;
        logic [15:0] rank;
        logic        fallback;
        logic        dropped;
        logic        last;
    } node_rank_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [6:0]  cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;

    graph_item_t send_q[$];
    node_rank_t  rank_q[$];
    int          fail_count = 0;
    int          idle_cycles = 0;

    // local copy of the graph state
    int          nodes_cfg = 0;
    int          edge_count = 0;
    logic        lost_edges = 1'b0;
    logic [5:0]  g_tail[EDGE_CAP];
    logic [5:0]  g_head[EDGE_CAP];
    logic [7:0]  g_gap[EDGE_CAP];

    dag_longest_path_rank dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always #5 clk = ~clk;

    function automatic int min_gap(input logic [7:0] raw);
        int g;
        g = $signed(raw);
        return (g < 1) ? 1 : g;
    endfunction

    // Ranking of the stored graph: Kahn order, forward and reverse pass.
    function automatic void rank_graph();
        int n, fill, hd, cur, best, c, low, id;
        int   indeg[64];
        int   order[64];
        int   rank[64];
        logic use_e[EDGE_CAP];
        logic any, fb;
        node_rank_t r;
        n = (nodes_cfg > MAX_NODES) ? MAX_NODES : nodes_cfg;
        for (int e = 0; e < edge_count; e++)
            use_e[e] = (g_tail[e] < n) && (g_head[e] < n);
        for (int i = 0; i < n; i++)
        begin
            rank[i] = 0;
            indeg[i] = 0;
        end
        for (int e = 0; e < edge_count; e++)
            if (use_e[e]) indeg[g_head[e]]++;
        fill = 0;
        hd = 0;
        for (int i = 0; i < n; i++)
            if (indeg[i] == 0) order[fill++] = i;
        while (hd < fill)
        begin
            cur = order[hd++];
            for (int e = 0; e < edge_count; e++)
                if (use_e[e] && g_tail[e] == cur)
                begin
                    indeg[g_head[e]]--;
                    if (indeg[g_head[e]] == 0 && fill < MAX_NODES) order[fill++] = g_head[e];
                end
        end
        fb = (fill != n);
        if (fb)
            for (int i = 0; i < n; i++) order[i] = i;
        // forward pass, saturating
        for (int k = 0; k < n; k++)
        begin
            id = order[k];
            best = 0;
            for (int e = 0; e < edge_count; e++)
                if (use_e[e] && g_head[e] == id)
                begin
                    c = rank[g_tail[e]] + min_gap(g_gap[e]);
                    if (c > 65535) c = 65535;
                    if (c > best) best = c;
                end
            rank[id] = best;
        end
        // reverse tightening pass
        for (int k = n - 1; k >= 0; k--)
        begin
            id = order[k];
            any = 1'b0;
            low = 0;
            for (int e = 0; e < edge_count; e++)
                if (use_e[e] && g_tail[e] == id)
                begin
                    c = rank[g_head[e]] - min_gap(g_gap[e]);
                    if (!any || c < low) low = c;
                    any = 1'b1;
                end
            if (any && low > rank[id]) rank[id] = low;
        end
        for (int i = 0; i < n; i++)
        begin
            r.node = i[5:0];
            r.rank = rank[i][15:0];
            r.fallback = fb;
            r.dropped = lost_edges;
            r.last = (i == n - 1);
            rank_q.insert(rank_q.size(), r);
        end
        edge_count = 0;
        lost_edges = 1'b0;
    endfunction

    function automatic void accept_item(input graph_item_t it);
        if (it.op == OP_RUN)
            rank_graph();
        else if (edge_count >= EDGE_CAP)
            lost_edges = 1'b1;
        else
        begin
            g_tail[edge_count] = it.tail;
            g_head[edge_count] = it.head;
            g_gap[edge_count] = it.gap;
            edge_count++;
        end
    endfunction

    task automatic report(input string what, input int got, input int want);
        $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    // Driver: bursts of random length separated by random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge clk)
    begin
        if (rst_n && (!s_tvalid || s_tready))
        begin
            if (gap_left > 0 || send_q.size() == 0)
            begin
                s_tvalid <= 1'b0;
                if (gap_left > 0) gap_left <= gap_left - 1;
            end
            else
            begin
                graph_item_t it;
                it = send_q.pop_front();
                s_tdata <= {4'b0, it.gap, it.head, it.tail};
                s_tuser <= it.op;
                s_tvalid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 8);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
        end
    end

    // Input monitor: accepted transactions feed the ranker
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            accept_item({s_tuser[0], s_tdata[5:0], s_tdata[11:6], s_tdata[19:12]});
    end

    // Result monitor with its own stall pattern
    int stall_mode = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= ($urandom_range(0, 4) == 0);
            endcase
            if (m_tvalid && m_tready)
            begin
                if (rank_q.size() == 0)
                    report("unexpected result, node", m_tdata[5:0], -1);
                else
                begin
                    node_rank_t w;
                    w = rank_q.pop_front();
                    if (m_tdata[5:0] != w.node) report("node_index", m_tdata[5:0], w.node);
                    if (m_tdata[21:6] != w.rank) report("node_rank", m_tdata[21:6], w.rank);
                    if (m_tdata[22] != w.fallback)
                        report("order_fallback", m_tdata[22], w.fallback);
                    if (m_tdata[23] != w.dropped)
                        report("edges_dropped", m_tdata[23], w.dropped);
                    if (m_tlast != w.last) report("last", m_tlast, w.last);
                end
            end
        end
    end

    // Watchdog on cycles with no transaction at all
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic add_edge(input int t, input int h, input int g);
        graph_item_t it;
        it.op = OP_ADD;
        it.tail = t[5:0];
        it.head = h[5:0];
        it.gap = g[7:0];
        send_q.insert(send_q.size(), it);
    endtask

    task automatic run_ranking();
        graph_item_t it;
        it.op = OP_RUN;
        it.tail = 6'($urandom());
        it.head = 6'($urandom());
        it.gap = 8'($urandom());
        send_q.insert(send_q.size(), it);
    endtask

    task automatic wait_drained();
        while (send_q.size() != 0 || s_tvalid || rank_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_nodes(input int n);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= n[6:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        nodes_cfg = n;
        cfg_valid <= 1'b0;
    endtask

    // Random graph phase with mostly small node counts
    task automatic random_phase();
        int n, ne, span;
        case ($urandom_range(0, 9))
            0: n = $urandom_range(65, 127);
            1: n = 64;
            default: n = $urandom_range(1, 12);
        endcase
        set_nodes(n);
        ne = (n > 12) ? $urandom_range(0, 10) : $urandom_range(0, 14);
        span = (n > 64) ? 64 : n;
        for (int i = 0; i < ne; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                add_edge($urandom_range(0, 63), $urandom_range(0, 63), $urandom);
            else if ($urandom_range(0, 3) != 0)
            begin
                // edge from lower to higher index; equal ends make a self loop
                int a, b;
                a = $urandom_range(0, span - 1);
                b = $urandom_range(0, span - 1);
                if (a > b) add_edge(b, a, $urandom);
                else add_edge(a, b, $urandom);
            end
            else
                add_edge($urandom_range(0, span), $urandom_range(0, span), $urandom);
        end
        run_ranking();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // empty graph: no results, store still emptied
        set_nodes(0);
        add_edge(0, 1, 5);
        run_ranking();

        // chain with gap extremes and out-of-range endpoints
        set_nodes(4);
        add_edge(0, 1, -128);
        add_edge(1, 2, 127);
        add_edge(2, 3, 0);
        add_edge(0, 3, 1);
        add_edge(63, 0, 127);
        add_edge(3, 42, 2);
        run_ranking();

        // cycle plus self loop forces identity order
        set_nodes(3);
        add_edge(0, 1, 3);
        add_edge(1, 2, 4);
        add_edge(2, 0, -1);
        add_edge(1, 1, 2);
        run_ranking();

        // full node range and a count above the maximum
        set_nodes(64);
        add_edge(0, 63, 127);
        add_edge(63, 21, 42);
        add_edge(42, 63, 85);
        run_ranking();
        set_nodes(127);
        add_edge(62, 1, 9);
        run_ranking();

        // store overflow on a tiny graph
        set_nodes(2);
        for (int i = 0; i < EDGE_CAP + 2; i++)
            add_edge(i % 2, 1, $urandom);
        run_ranking();
        run_ranking();

        // a few random graphs
        for (int sent = 0; sent < 30; )
        begin
            random_phase();
            sent += send_q.size();
        end

        wait_drained();
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
